/* rtl/core/kdpt_pkg.sv */
// ----------------------------------------------------------------------------
// kdpt_pkg
// Shared constants and types for the key double-press tracker.
// ----------------------------------------------------------------------------
`default_nettype none

package kdpt_pkg;

  localparam int unsigned KeyCountDef    = 128;
  localparam int unsigned ButtonCountDef = 8;

  // Number of distinct values of the key index field
  localparam int unsigned KeyIdxRange = 128;
  localparam int unsigned KeyIdxW     = 7;
  localparam int unsigned TimeW       = 48;
  localparam int unsigned WindowW     = 32;

  localparam logic [WindowW-1:0] WindowRst = 32'd250000000;

  typedef enum logic [2:0] {
    ST_IDLE      = 3'd0,
    ST_PRESS     = 3'd1,
    ST_HOLD      = 3'd2,
    ST_RELEASE   = 3'd3,
    ST_LISTEN    = 3'd4,
    ST_PRESS_D   = 3'd5,
    ST_HOLD_D    = 3'd6,
    ST_RELEASE_D = 3'd7
  } key_state_e;

endpackage

`default_nettype wire

/* rtl/core/key_double_press_tracker_core.sv */
// ----------------------------------------------------------------------------
// key_double_press_tracker_core
// Per-key press state tracker with double-press detection and mouse buttons.
// ----------------------------------------------------------------------------
//  channel  | direction | handshake               | payload
//  ---------+-----------+-------------------------+-------------------------------
//  in       | sink      | in_valid_i / in_stall_o | is_mouse, key_index, pressed,
//           |           |                         | time_now
//  out      | source    | out_valid_o/out_stall_i | new_state, press/hold/release/
//           |           |                         | double flags
//  cfg      | sink      | cfg_valid_i/cfg_ready_o | double_press_window
//
// One sample per cycle sustained while the output is not stalled. Stage 1
// holds the sample and the registered read of the key memory, stage 2 is the
// result register that presents the result. A write-to-read bypass covers a
// sample that hits the key being written by the sample ahead of it.
// Reset clears all key valid bits and button states; no clearing pass needed.
// A stalled result holds stage 2; the input stalls only when stage 1 is also
// full.
// ----------------------------------------------------------------------------
`default_nettype none

module key_double_press_tracker_core #(
  parameter int unsigned KEY_COUNT    = kdpt_pkg::KeyCountDef,
  parameter int unsigned BUTTON_COUNT = kdpt_pkg::ButtonCountDef
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,

  input  wire logic                          in_valid_i,
  output logic                               in_stall_o,
  input  wire logic                          is_mouse_i,
  input  wire logic [kdpt_pkg::KeyIdxW-1:0]  key_index_i,
  input  wire logic                          pressed_i,
  input  wire logic [kdpt_pkg::TimeW-1:0]    time_now_i,

  output logic                               out_valid_o,
  input  wire logic                          out_stall_i,
  output logic [2:0]                         new_state_o,
  output logic                               press_flag_o,
  output logic                               hold_flag_o,
  output logic                               release_flag_o,
  output logic                               double_flag_o,

  input  wire logic                          cfg_valid_i,
  output logic                               cfg_ready_o,
  input  wire logic [kdpt_pkg::WindowW-1:0]  cfg_data_i
);

  import kdpt_pkg::*;

  // Only indices below the field range can ever be addressed
  localparam int unsigned KeyDepth = (KEY_COUNT < KeyIdxRange) ? KEY_COUNT : KeyIdxRange;
  localparam int unsigned KeyAw    = (KeyDepth > 1) ? $clog2(KeyDepth) : 1;
  localparam int unsigned BtnW     = (BUTTON_COUNT > 1) ? $clog2(BUTTON_COUNT) : 1;
  localparam int unsigned EntryW   = TimeW + 3;

  // --------------------------------------------------------------------------
  // Configuration
  // --------------------------------------------------------------------------
  logic [WindowW-1:0] window_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      window_q <= WindowRst;
    end else if (cfg_valid_i && cfg_ready_o) begin
      window_q <= cfg_data_i;
    end
  end

  // --------------------------------------------------------------------------
  // Handshake
  // --------------------------------------------------------------------------
  logic s1_vld_q;
  logic out_vld_q;
  logic s1_go_w;
  logic in_acc_w;

  assign s1_go_w    = !out_vld_q || !out_stall_i;
  assign in_stall_o = s1_vld_q && !s1_go_w;
  assign in_acc_w   = in_valid_i && !in_stall_o;

  // --------------------------------------------------------------------------
  // Button index table: key index modulo button count
  // --------------------------------------------------------------------------
  logic [BtnW-1:0] btn_lut [KeyIdxRange];

  for (genvar gi = 0; gi < KeyIdxRange; gi++) begin : g_btn_lut
    assign btn_lut[gi] = BtnW'(gi % BUTTON_COUNT);
  end

  // --------------------------------------------------------------------------
  // Stage 1: input register and key memory read
  // --------------------------------------------------------------------------
  logic                mouse_q;
  logic                pressed_q;
  logic                inrange_q;
  logic [KeyAw-1:0]    addr_q;
  logic [BtnW-1:0]     btn_q;
  logic [TimeW-1:0]    time_q;
  logic [EntryW-1:0]   rd_entry_q;
  logic                rd_vld_q;

  logic [EntryW-1:0]   key_mem [KeyDepth];
  logic [KeyDepth-1:0] key_vld_q;
  logic [1:0]          btn_state_q [BUTTON_COUNT];

  logic                in_range_w;
  logic [KeyAw-1:0]    rd_addr_w;
  logic                wr_en_w;
  logic [EntryW-1:0]   wr_entry_w;
  logic                btn_wr_w;
  logic                fwd_w;

  assign in_range_w = (32'(key_index_i) < KEY_COUNT);
  assign rd_addr_w  = in_range_w ? key_index_i[KeyAw-1:0] : '0;
  assign fwd_w      = wr_en_w && (addr_q == rd_addr_w);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q <= 1'b0;
    end else if (in_acc_w) begin
      s1_vld_q <= 1'b1;
    end else if (s1_go_w) begin
      s1_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc_w) begin
      mouse_q   <= is_mouse_i;
      pressed_q <= pressed_i;
      inrange_q <= in_range_w;
      addr_q    <= rd_addr_w;
      btn_q     <= btn_lut[key_index_i];
      time_q    <= time_now_i;
      // Bypass the entry written in this same cycle
      if (fwd_w) begin
        rd_entry_q <= wr_entry_w;
        rd_vld_q   <= 1'b1;
      end else begin
        rd_entry_q <= key_mem[rd_addr_w];
        rd_vld_q   <= key_vld_q[rd_addr_w];
      end
    end
  end

  // --------------------------------------------------------------------------
  // Next-state logic
  // --------------------------------------------------------------------------
  key_state_e       cur_key_w;
  key_state_e       nxt_key_w;
  logic [TimeW-1:0] start_w;
  logic [TimeW-1:0] nxt_start_w;
  logic [TimeW-1:0] gap_w;
  logic             in_window_w;
  key_state_e       cur_btn_w;
  key_state_e       nxt_btn_w;
  key_state_e       res_w;

  assign cur_key_w   = rd_vld_q ? key_state_e'(rd_entry_q[2:0]) : ST_IDLE;
  assign start_w     = rd_entry_q[EntryW-1:3];
  assign gap_w       = time_q - start_w;
  assign in_window_w = (gap_w <= TimeW'(window_q));

  always_comb begin
    nxt_start_w = start_w;
    unique case (cur_key_w)
      ST_IDLE: begin
        if (pressed_q) begin
          nxt_key_w   = ST_PRESS;
          nxt_start_w = time_q;
        end else begin
          nxt_key_w = ST_IDLE;
        end
      end
      ST_PRESS:     nxt_key_w = pressed_q ? ST_HOLD : ST_RELEASE;
      ST_HOLD:      nxt_key_w = pressed_q ? ST_HOLD : ST_RELEASE;
      ST_RELEASE:   nxt_key_w = ST_LISTEN;
      ST_LISTEN: begin
        if (!pressed_q) begin
          nxt_key_w = ST_LISTEN;
        end else if (in_window_w) begin
          nxt_key_w = ST_PRESS_D;
        end else begin
          nxt_key_w   = ST_PRESS;
          nxt_start_w = time_q;
        end
      end
      ST_PRESS_D:   nxt_key_w = pressed_q ? ST_HOLD_D : ST_RELEASE_D;
      ST_HOLD_D:    nxt_key_w = pressed_q ? ST_HOLD_D : ST_RELEASE_D;
      ST_RELEASE_D: nxt_key_w = ST_IDLE;
      default:      nxt_key_w = ST_IDLE;
    endcase
  end

  assign cur_btn_w = key_state_e'({1'b0, btn_state_q[btn_q]});

  always_comb begin
    unique case (cur_btn_w)
      ST_IDLE:    nxt_btn_w = pressed_q ? ST_PRESS : ST_IDLE;
      ST_PRESS:   nxt_btn_w = pressed_q ? ST_HOLD : ST_RELEASE;
      ST_HOLD:    nxt_btn_w = pressed_q ? ST_HOLD : ST_RELEASE;
      ST_RELEASE: nxt_btn_w = ST_IDLE;
      default:    nxt_btn_w = ST_IDLE;
    endcase
  end

  // Out-of-range keys leave all state alone and report idle
  always_comb begin
    priority if (mouse_q) begin
      res_w = nxt_btn_w;
    end else if (inrange_q) begin
      res_w = nxt_key_w;
    end else begin
      res_w = ST_IDLE;
    end
  end

  // --------------------------------------------------------------------------
  // State write-back
  // --------------------------------------------------------------------------
  assign wr_en_w    = s1_vld_q && s1_go_w && !mouse_q && inrange_q;
  assign wr_entry_w = {nxt_start_w, nxt_key_w};
  assign btn_wr_w   = s1_vld_q && s1_go_w && mouse_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_w) begin
      key_mem[addr_q] <= wr_entry_w;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_vld_q <= '0;
    end else if (wr_en_w) begin
      key_vld_q[addr_q] <= 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < BUTTON_COUNT; i++) begin
        btn_state_q[i] <= 2'(ST_IDLE);
      end
    end else if (btn_wr_w) begin
      btn_state_q[btn_q] <= nxt_btn_w[1:0];
    end
  end

  // --------------------------------------------------------------------------
  // Stage 2: result register
  // --------------------------------------------------------------------------
  key_state_e out_state_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (s1_go_w) begin
      out_vld_q <= s1_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_go_w && s1_vld_q) begin
      out_state_q <= res_w;
    end
  end

  assign out_valid_o    = out_vld_q;
  assign new_state_o    = out_state_q;
  assign press_flag_o   = (out_state_q == ST_PRESS)   || (out_state_q == ST_PRESS_D);
  assign hold_flag_o    = (out_state_q == ST_HOLD)    || (out_state_q == ST_HOLD_D);
  assign release_flag_o = (out_state_q == ST_RELEASE) || (out_state_q == ST_RELEASE_D);
  assign double_flag_o  = (out_state_q == ST_PRESS_D);

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
`ifndef SYNTH
  a_stall_needs_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (out_valid_o && out_stall_i && s1_vld_q))
    else $error("input stalled while the pipeline can advance");

  a_double_is_press: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && double_flag_o) |-> press_flag_o)
    else $error("double press reported without press");

  a_flags_exclusive: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> $onehot0({press_flag_o, hold_flag_o, release_flag_o}))
    else $error("more than one phase flag set");

  a_mouse_four_states: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_vld_q && mouse_q) |-> (res_w[2] == 1'b0))
    else $error("mouse button left the four-state subset");

  a_one_store_written: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(wr_en_w && btn_wr_w))
    else $error("key and button stores written by one transfer");
`endif

endmodule

`default_nettype wire

/* bench/tb_key_double_press_tracker_core.sv */
// ----------------------------------------------------------------------------
// tb_key_double_press_tracker_core
// Self-checking bench: random press/release traffic across window settings.
// Accepted samples run through an in-bench tracker model that feeds a queue
// of expected results; every result transfer is checked against its head.
// ----------------------------------------------------------------------------

module tb_key_double_press_tracker_core;

  import kdpt_pkg::*;

  localparam int unsigned KeyCount      = KeyCountDef;
  localparam int unsigned ButtonCount   = ButtonCountDef;
  localparam int unsigned HoldOffCycles = 300;
  localparam int unsigned QuietLimit    = 2000;
  localparam int unsigned ReportCap     = 200;

  typedef struct {
    logic               is_mouse;
    logic [KeyIdxW-1:0] key_index;
    logic               pressed;
    logic [TimeW-1:0]   time_now;
  } key_sample_t;

  typedef struct {
    key_state_e state;
    logic       press;
    logic       hold;
    logic       rel;
    logic       dbl;
  } key_result_t;

  logic                clk_i       = 1'b0;
  logic                rst_ni      = 1'b0;
  logic                in_valid_i  = 1'b0;
  logic                in_stall_o;
  logic                is_mouse_i  = 1'b0;
  logic [KeyIdxW-1:0]  key_index_i = '0;
  logic                pressed_i   = 1'b0;
  logic [TimeW-1:0]    time_now_i  = '0;
  logic                out_valid_o;
  logic                out_stall_i = 1'b0;
  logic [2:0]          new_state_o;
  logic                press_flag_o;
  logic                hold_flag_o;
  logic                release_flag_o;
  logic                double_flag_o;
  logic                cfg_valid_i = 1'b0;
  logic                cfg_ready_o;
  logic [WindowW-1:0]  cfg_data_i  = '0;

  // tracker model state
  key_state_e          key_state   [KeyCount];
  logic [TimeW-1:0]    press_start [KeyCount];
  key_state_e          button_state[ButtonCount];
  logic [WindowW-1:0]  double_window = WindowRst;

  key_sample_t         pending_samples[$];
  key_result_t         expected_results[$];
  key_sample_t         offered;
  key_result_t         arrived_want;
  logic [TimeW-1:0]    now_ns = '0;

  int unsigned samples_queued   = 0;
  int unsigned samples_accepted = 0;
  int unsigned mouse_samples    = 0;
  int unsigned results_checked  = 0;
  int unsigned doubles_seen     = 0;
  int unsigned windows_used     = 1;
  int unsigned mismatches       = 0;
  int unsigned send_gap         = 0;
  int unsigned stall_left       = 0;
  bit          send_calm        = 1'b0;
  bit          recv_calm        = 1'b0;
  bit          pressure_go      = 1'b0;
  logic        receiver_hold    = 1'b0;

  key_double_press_tracker_core u_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .is_mouse_i     (is_mouse_i),
    .key_index_i    (key_index_i),
    .pressed_i      (pressed_i),
    .time_now_i     (time_now_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .new_state_o    (new_state_o),
    .press_flag_o   (press_flag_o),
    .hold_flag_o    (hold_flag_o),
    .release_flag_o (release_flag_o),
    .double_flag_o  (double_flag_o),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_data_i     (cfg_data_i)
  );

  always #1 clk_i = ~clk_i;

  initial begin
    for (int i = 0; i < KeyCount; i++) begin
      key_state[i]   = ST_IDLE;
      press_start[i] = '0;
    end
    for (int i = 0; i < ButtonCount; i++) begin
      button_state[i] = ST_IDLE;
    end
  end

  // Apply one sample to the tracker model and return the result it yields.
  function automatic key_result_t advance_tracker(key_sample_t s);
    key_result_t      r;
    key_state_e       cur;
    key_state_e       nxt;
    logic [TimeW-1:0] gap;
    int unsigned      btn;
    nxt = ST_IDLE;
    if (s.is_mouse) begin
      btn = s.key_index % ButtonCount;
      cur = button_state[btn];
      if (s.pressed && cur == ST_IDLE) nxt = ST_PRESS;
      else if (!s.pressed && (cur == ST_PRESS || cur == ST_HOLD)) nxt = ST_RELEASE;
      else if (cur == ST_PRESS) nxt = ST_HOLD;
      else if (cur == ST_RELEASE) nxt = ST_IDLE;
      else nxt = cur;
      button_state[btn] = nxt;
    end else if (s.key_index < KeyCount) begin
      cur = key_state[s.key_index];
      nxt = cur;
      gap = s.time_now - press_start[s.key_index];
      case (cur)
        ST_IDLE: begin
          if (s.pressed) begin
            nxt = ST_PRESS;
            press_start[s.key_index] = s.time_now;
          end
        end
        ST_PRESS, ST_HOLD: nxt = s.pressed ? ST_HOLD : ST_RELEASE;
        ST_RELEASE: nxt = ST_LISTEN;
        ST_LISTEN: begin
          // window is inclusive; the gap wraps at the timestamp width
          if (s.pressed && gap <= {16'd0, double_window}) begin
            nxt = ST_PRESS_D;
          end else if (s.pressed) begin
            nxt = ST_PRESS;
            press_start[s.key_index] = s.time_now;
          end
        end
        ST_PRESS_D, ST_HOLD_D: nxt = s.pressed ? ST_HOLD_D : ST_RELEASE_D;
        ST_RELEASE_D: nxt = ST_IDLE;
        default: nxt = cur;
      endcase
      key_state[s.key_index] = nxt;
    end
    r.state = nxt;
    r.press = (nxt == ST_PRESS || nxt == ST_PRESS_D);
    r.hold  = (nxt == ST_HOLD || nxt == ST_HOLD_D);
    r.rel   = (nxt == ST_RELEASE || nxt == ST_RELEASE_D);
    r.dbl   = (nxt == ST_PRESS_D);
    return r;
  endfunction

  function automatic int unsigned draw_gap(bit calm);
    if (calm) return 0;
    return ($urandom_range(0, 1) != 0) ? 0 : $urandom_range(1, 17);
  endfunction

  task automatic report_mismatch(input string what, input logic [47:0] got,
                                 input logic [47:0] want);
    mismatches++;
    // keep the log bounded on a badly broken block
    if (mismatches <= ReportCap)
      $display("mismatch at result %0d, %s: got %0h, expected %0h",
               results_checked, what, got, want);
  endtask

  // Sender: hold a stalled transfer, otherwise idle or offer the next sample.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      send_gap = 0;
    end else begin
      if (in_valid_i && !in_stall_o) begin
        expected_results.push_back(advance_tracker(offered));
        if (offered.is_mouse) mouse_samples++;
        samples_accepted++;
        send_gap = draw_gap(send_calm);
      end
      if (!(in_valid_i && in_stall_o)) begin
        if (send_gap != 0) begin
          send_gap--;
          in_valid_i <= 1'b0;
        end else if (pending_samples.size() != 0) begin
          offered = pending_samples.pop_front();
          is_mouse_i  <= offered.is_mouse;
          key_index_i <= offered.key_index;
          pressed_i   <= offered.pressed;
          time_now_i  <= offered.time_now;
          in_valid_i  <= 1'b1;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // Receiver: check each result transfer, then stall for a drawn stretch.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
      stall_left = 0;
    end else begin
      if (out_valid_o && !out_stall_i) begin
        if (expected_results.size() == 0) begin
          report_mismatch("result with nothing pending", new_state_o, '0);
        end else begin
          arrived_want = expected_results.pop_front();
          if (new_state_o !== arrived_want.state)
            report_mismatch("new_state", new_state_o, arrived_want.state);
          if (press_flag_o !== arrived_want.press)
            report_mismatch("press_flag", press_flag_o, arrived_want.press);
          if (hold_flag_o !== arrived_want.hold)
            report_mismatch("hold_flag", hold_flag_o, arrived_want.hold);
          if (release_flag_o !== arrived_want.rel)
            report_mismatch("release_flag", release_flag_o, arrived_want.rel);
          if (double_flag_o !== arrived_want.dbl)
            report_mismatch("double_flag", double_flag_o, arrived_want.dbl);
          if (arrived_want.dbl) doubles_seen++;
        end
        results_checked++;
        stall_left = draw_gap(recv_calm);
      end
      out_stall_i <= receiver_hold || (stall_left != 0);
      if (stall_left != 0) stall_left--;
    end
  end

  // Long receiver hold-off so the pipeline fills and stalls its input.
  initial begin : receiver_hold_off
    wait (pressure_go);
    @(posedge clk_i);
    receiver_hold <= 1'b1;
    repeat (HoldOffCycles) @(posedge clk_i);
    receiver_hold <= 1'b0;
  end

  initial begin : watchdog
    int unsigned quiet;
    quiet = 0;
    while (quiet < QuietLimit) begin
      @(posedge clk_i);
      if (!rst_ni || (in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) ||
          (cfg_valid_i && cfg_ready_o))
        quiet = 0;
      else
        quiet++;
    end
    $display("key_double_press_tracker_core verification failed");
    $finish;
  end

  task automatic queue_sample(input bit mouse, input logic [KeyIdxW-1:0] idx,
                              input bit level, input logic [TimeW-1:0] t);
    key_sample_t s;
    s.is_mouse  = mouse;
    s.key_index = idx;
    s.pressed   = level;
    s.time_now  = t;
    pending_samples.push_back(s);
    samples_queued++;
  endtask

  // Press, hold, release, listen, then a second press near or far from the window.
  task automatic queue_key_cycle(input logic [KeyIdxW-1:0] key, input logic [TimeW-1:0] t0);
    logic [TimeW-1:0] t1;
    if ($urandom_range(0, 3) != 0)
      t1 = t0 + double_window + TimeW'($urandom_range(0, 6)) - TimeW'(3);
    else
      t1 = t0 + {16'($urandom), $urandom};
    queue_sample(1'b0, key, 1'b1, t0);
    repeat ($urandom_range(0, 3)) queue_sample(1'b0, key, 1'b1, t0 + 1);
    repeat ($urandom_range(1, 3)) queue_sample(1'b0, key, 1'b0, t0 + 2);
    queue_sample(1'b0, key, 1'b1, t1);
    repeat ($urandom_range(0, 3)) queue_sample(1'b0, key, 1'b1, t1 + 1);
    repeat ($urandom_range(1, 3)) queue_sample(1'b0, key, 1'b0, t1 + 2);
  endtask

  task automatic queue_random(input int unsigned count);
    int unsigned stop;
    int unsigned pick;
    stop = samples_queued + count;
    while (samples_queued < stop) begin
      pick = $urandom_range(0, 9);
      now_ns += TimeW'($urandom_range(1, 2000000));
      // now and then park the clock right below the wrap point
      if ($urandom_range(0, 15) == 0) now_ns = '1 - TimeW'($urandom_range(0, 3000));
      if (pick < 6) begin
        queue_key_cycle(KeyIdxW'($urandom_range(0, KeyIdxRange - 1)), now_ns);
      end else if (pick < 8) begin
        pick = $urandom_range(0, KeyIdxRange - 1);
        queue_sample(1'b1, KeyIdxW'(pick), 1'b1, now_ns);
        repeat ($urandom_range(0, 3)) queue_sample(1'b1, KeyIdxW'(pick), 1'b1, now_ns);
        repeat ($urandom_range(1, 3)) queue_sample(1'b1, KeyIdxW'(pick), 1'b0, now_ns);
      end else begin
        repeat ($urandom_range(1, 3))
          queue_sample($urandom_range(0, 1), KeyIdxW'($urandom_range(0, KeyIdxRange - 1)),
                       $urandom_range(0, 1), {16'($urandom), $urandom});
      end
    end
  endtask

  task automatic drain_results();
    while (samples_accepted != samples_queued || expected_results.size() != 0)
      @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic set_double_window(input logic [WindowW-1:0] value);
    cfg_data_i  <= value;
    cfg_valid_i <= 1'b1;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    cfg_valid_i   <= 1'b0;
    double_window = value;
    windows_used++;
  endtask

  initial begin : stimulus
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // key 0: full double press with the gap exactly at the reset window
    queue_sample(1'b0, 7'd0, 1'b1, 48'd0);
    queue_sample(1'b0, 7'd0, 1'b1, 48'd10);
    queue_sample(1'b0, 7'd0, 1'b0, 48'd20);
    queue_sample(1'b0, 7'd0, 1'b0, 48'd30);
    queue_sample(1'b0, 7'd0, 1'b1, {16'd0, WindowRst});
    queue_sample(1'b0, 7'd0, 1'b1, 48'd40);
    queue_sample(1'b0, 7'd0, 1'b0, 48'd50);
    queue_sample(1'b0, 7'd0, 1'b0, 48'd60);
    // release on an idle key stays idle
    queue_sample(1'b0, 7'd64, 1'b0, 48'd70);
    // key 5: second press one unit past the window starts a new press
    queue_sample(1'b0, 7'd5, 1'b1, 48'd100);
    queue_sample(1'b0, 7'd5, 1'b0, 48'd100);
    queue_sample(1'b0, 7'd5, 1'b0, 48'd100);
    queue_sample(1'b0, 7'd5, 1'b1, 48'd101 + WindowRst);
    // key 127: first press at the top of time, second after the wrap
    queue_sample(1'b0, 7'd127, 1'b1, '1);
    queue_sample(1'b0, 7'd127, 1'b0, '1);
    queue_sample(1'b0, 7'd127, 1'b0, '1);
    queue_sample(1'b0, 7'd127, 1'b1, {16'd0, WindowRst} - 48'd1);
    // mouse: index 127 and 7 alias to one button, 8 to button 0
    queue_sample(1'b1, 7'd127, 1'b1, '1);
    queue_sample(1'b1, 7'd127, 1'b1, '0);
    queue_sample(1'b1, 7'd7, 1'b0, '0);
    queue_sample(1'b1, 7'd7, 1'b0, '0);
    queue_sample(1'b1, 7'd7, 1'b1, '0);
    queue_sample(1'b1, 7'd8, 1'b0, '0);
    queue_random(300);
    drain_results();

    set_double_window('0);
    queue_random(200);
    drain_results();

    set_double_window('1);
    queue_random(200);
    drain_results();

    // back-to-back sender against a receiver that holds off
    set_double_window($urandom);
    send_calm   = 1'b1;
    pressure_go = 1'b1;
    queue_random(200);
    drain_results();

    set_double_window(WindowW'($urandom_range(1, 5000)));
    recv_calm = 1'b1;
    queue_random(200);
    drain_results();
    repeat (8) @(posedge clk_i);

    $display("covered %0d samples (%0d mouse) under %0d window settings, %0d results checked",
             samples_accepted, mouse_samples, windows_used, results_checked);
    $display("%0d double presses seen, one receiver hold-off of %0d cycles",
             doubles_seen, HoldOffCycles);
    if (mismatches == 0) begin
      $display("key_double_press_tracker_core verification clean");
    end else begin
      $display("key_double_press_tracker_core verification failed");
    end
    $finish;
  end

endmodule

/* filelist.f */
rtl/core/kdpt_pkg.sv
rtl/core/key_double_press_tracker_core.sv
bench/tb_key_double_press_tracker_core.sv
